### rtl/eps_pkg.sv
// Shared types and constants for the I2C EEPROM page sequencer.
package eps_pkg;

  // Page geometry.
  localparam int PAGE_BYTES = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;

  // Item kinds on the request channel.
  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_STATUS = 2'd3
  } func_t;

  // Bus actions on the response channel.
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_TX      = 3'd2,
    ACT_RX_ACK  = 3'd3,
    ACT_RX_NACK = 3'd4,
    ACT_STOP    = 3'd5
  } act_t;

  // Controller status codes.
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_RESTART   = 8'h10;
  localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;
  localparam logic [7:0] RW_READ_BIT  = 8'h01;

  // Device address byte after reset.
  localparam logic [7:0] DEV_ADDR_RST = 8'hA0;

  // One response beat.
  typedef struct packed {
    act_t             action;
    logic [7:0]       tx_byte;
    logic             rx_valid;
    logic [7:0]       rx_byte;
    logic [IDX_W-1:0] rx_index;
    logic             done_res;
    logic             failed;
  } rsp_t;

endpackage

### rtl/eps_ifs.sv
// Channel interfaces: request, response and configuration write.
interface eps_req_if;
  import eps_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [7:0]       bus_status;
  logic [7:0]       data_byte;
  logic [IDX_W-1:0] byte_index;
  logic [7:0]       block_bits;
  logic [7:0]       word_addr;

  modport source (output valid, func, bus_status, data_byte, byte_index, block_bits,
                  word_addr, input ready);
  modport sink (input valid, func, bus_status, data_byte, byte_index, block_bits,
                word_addr, output ready);
endinterface

interface eps_rsp_if;
  import eps_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       action;
  logic [7:0]       tx_byte;
  logic             rx_valid;
  logic [7:0]       rx_byte;
  logic [IDX_W-1:0] rx_index;
  logic             done_res;
  logic             failed;

  modport source (output valid, action, tx_byte, rx_valid, rx_byte, rx_index, done_res,
                  failed, input ready);
  modport sink (input valid, action, tx_byte, rx_valid, rx_byte, rx_index, done_res,
                failed, output ready);
endinterface

interface eps_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/eps_page_buf.sv
// Page write buffer: one write port, one combinational read port.
module eps_page_buf (
  input  logic                      clk,
  input  logic                      we,
  input  logic [eps_pkg::IDX_W-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic [eps_pkg::IDX_W-1:0] raddr,
  output logic [7:0]                rdata
);
  import eps_pkg::*;

  logic [7:0] page [PAGE_BYTES];

  // Load beats write one byte; contents are undefined until written.
  always_ff @(posedge clk) begin
    if (we) begin
      page[waddr] <= wdata;
    end
  end

  assign rdata = page[raddr];

endmodule

### rtl/eps_ctrl.sv
// Transaction sequencer: checks status codes and registers one response per beat.
module eps_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [7:0]                dev_sel,
  eps_req_if.sink                   req,
  eps_rsp_if.source                 rsp,
  output logic                      buf_we,
  output logic [eps_pkg::IDX_W-1:0] buf_raddr,
  input  logic [7:0]                buf_rdata
);
  import eps_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_SLA_W,
    PH_WORD,
    PH_WDATA,
    PH_RESTART,
    PH_SLA_R,
    PH_RDATA
  } phase_t;

  phase_t           phase, phase_next;
  logic             is_read, is_read_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       addr_block, addr_block_next;
  logic [7:0]       start_word, start_word_next;
  logic             out_valid;
  rsp_t             res, res_next;

  logic             accept;
  logic [CNT_W:0]   cnt_inc;
  logic             last_byte;
  logic [7:0]       expected;
  func_t            func;

  assign accept    = req.valid && req.ready;
  assign req.ready = !out_valid || rsp.ready;
  assign func      = func_t'(req.func);

  assign cnt_inc   = {1'b0, byte_count} + (CNT_W+1)'(1);
  assign last_byte = cnt_inc >= (CNT_W+1)'(PAGE_BYTES);

  // Buffer address: first byte after the word address, else the next byte.
  assign buf_raddr = (phase == PH_WORD) ? '0 : cnt_inc[IDX_W-1:0];

  // Status code the current phase waits for.
  always_comb begin
    case (phase)
      PH_START:   expected = ST_START;
      PH_SLA_W:   expected = ST_SLA_W_ACK;
      PH_WORD:    expected = ST_DATA_ACK;
      PH_WDATA:   expected = ST_DATA_ACK;
      PH_RESTART: expected = ST_RESTART;
      PH_SLA_R:   expected = ST_SLA_R_ACK;
      default:    expected = last_byte ? ST_RX_NACK : ST_RX_ACK;
    endcase
  end

  // Next state and response for the beat on the request channel.
  always_comb begin
    phase_next      = phase;
    is_read_next    = is_read;
    byte_count_next = byte_count;
    addr_block_next = addr_block;
    start_word_next = start_word;
    res_next        = '0;
    buf_we          = 1'b0;
    case (func)
      FUNC_LOAD: begin
        buf_we = accept && ({1'b0, req.byte_index} < (IDX_W+1)'(PAGE_BYTES));
      end
      FUNC_WRITE, FUNC_READ: begin
        if (phase == PH_IDLE) begin
          is_read_next    = (func == FUNC_READ);
          addr_block_next = req.block_bits;
          start_word_next = req.word_addr;
          byte_count_next = '0;
          phase_next      = PH_START;
          res_next.action = ACT_START;
        end
      end
      FUNC_STATUS: begin
        if (phase != PH_IDLE) begin
          if (req.bus_status != expected) begin
            // Abort; only a data phase needs a stop on the bus.
            res_next.action   = (phase == PH_WDATA || phase == PH_RDATA) ? ACT_STOP
                                                                         : ACT_NONE;
            res_next.done_res = 1'b1;
            res_next.failed   = 1'b1;
            phase_next        = PH_IDLE;
          end else begin
            case (phase)
              PH_START: begin
                res_next.action  = ACT_TX;
                res_next.tx_byte = dev_sel | addr_block;
                phase_next       = PH_SLA_W;
              end
              PH_SLA_W: begin
                res_next.action  = ACT_TX;
                res_next.tx_byte = start_word;
                phase_next       = PH_WORD;
              end
              PH_WORD: begin
                if (is_read) begin
                  res_next.action = ACT_START;
                  phase_next      = PH_RESTART;
                end else begin
                  byte_count_next  = '0;
                  res_next.action  = ACT_TX;
                  res_next.tx_byte = buf_rdata;
                  phase_next       = PH_WDATA;
                end
              end
              PH_WDATA: begin
                byte_count_next = cnt_inc[CNT_W-1:0];
                if (last_byte) begin
                  res_next.action   = ACT_STOP;
                  res_next.done_res = 1'b1;
                  phase_next        = PH_IDLE;
                end else begin
                  res_next.action  = ACT_TX;
                  res_next.tx_byte = buf_rdata;
                end
              end
              PH_RESTART: begin
                res_next.action  = ACT_TX;
                res_next.tx_byte = dev_sel | addr_block | RW_READ_BIT;
                phase_next       = PH_SLA_R;
              end
              PH_SLA_R: begin
                // Count restarts at zero, so the last-byte test uses one byte.
                byte_count_next = '0;
                res_next.action = (PAGE_BYTES <= 1) ? ACT_RX_NACK : ACT_RX_ACK;
                phase_next      = PH_RDATA;
              end
              default: begin
                res_next.rx_valid = 1'b1;
                res_next.rx_byte  = req.data_byte;
                res_next.rx_index = byte_count[IDX_W-1:0];
                byte_count_next   = cnt_inc[CNT_W-1:0];
                if (last_byte) begin
                  res_next.action   = ACT_STOP;
                  res_next.done_res = 1'b1;
                  phase_next        = PH_IDLE;
                end else begin
                  res_next.action = (cnt_inc + (CNT_W+1)'(1) >= (CNT_W+1)'(PAGE_BYTES))
                                    ? ACT_RX_NACK : ACT_RX_ACK;
                end
              end
            endcase
          end
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  // Sequencer state and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      is_read    <= 1'b0;
      byte_count <= '0;
      addr_block <= '0;
      start_word <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        is_read    <= is_read_next;
        byte_count <= byte_count_next;
        addr_block <= addr_block_next;
        start_word <= start_word_next;
        out_valid  <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      res <= res_next;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.action   = res.action;
  assign rsp.tx_byte  = res.tx_byte;
  assign rsp.rx_valid = res.rx_valid;
  assign rsp.rx_byte  = res.rx_byte;
  assign rsp.rx_index = res.rx_index;
  assign rsp.done_res = res.done_res;
  assign rsp.failed   = res.failed;

endmodule

### rtl/i2c_eeprom_page_sequencer.sv
// Top level of the I2C EEPROM page sequencer.
// The block takes one request beat per clock and returns exactly one response beat
// for each from its output register in the next cycle; a new request is taken while
// a response waits as long as that response is being taken in the same cycle, so
// the sustained rate is one beat per cycle, set by the single status check and
// page buffer read between the request port and the response register. Load beats
// fill the 16-byte page buffer; a write or read start beat opens a transaction and
// each status beat is checked against the code the sequence expects, yielding the
// next bus action. The device address register is written on the cfg channel,
// which is always ready, and should only be changed while no transaction is open.
module i2c_eeprom_page_sequencer (
  input  logic      clk,
  input  logic      rst,
  eps_cfg_if.sink   cfg,
  eps_req_if.sink   req,
  eps_rsp_if.source rsp
);
  import eps_pkg::*;

  logic [7:0]       dev_sel;
  logic             buf_we;
  logic [IDX_W-1:0] buf_raddr;
  logic [7:0]       buf_rdata;

  // Device address register.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_sel <= DEV_ADDR_RST;
    end else if (cfg.valid) begin
      dev_sel <= cfg.data;
    end
  end

  eps_page_buf u_page_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (req.byte_index),
    .wdata (req.data_byte),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  eps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .dev_sel   (dev_sel),
    .req       (req),
    .rsp       (rsp),
    .buf_we    (buf_we),
    .buf_raddr (buf_raddr),
    .buf_rdata (buf_rdata)
  );

endmodule

### tb/sv/tb_i2c_eeprom_page_sequencer.sv
// Self-checking testbench for the I2C EEPROM page sequencer.
`timescale 1ns / 1ps

module tb_i2c_eeprom_page_sequencer;
  import eps_pkg::*;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Beats per random phase, one phase per device address setting.
  localparam int PHASE_BEATS = 320;
  // Mismatches reported in full; later ones are only counted.
  localparam int REPORT_LIMIT = 10;

  // Transaction phases tracked by the predictor.
  typedef enum logic [3:0] {
    TP_IDLE,
    TP_START,
    TP_SLA_W,
    TP_WORD,
    TP_WDATA,
    TP_RESTART,
    TP_SLA_R,
    TP_RDATA
  } txn_phase_t;

  // One request beat as the sender sees it.
  typedef struct {
    func_t            func;
    logic [7:0]       bus_status;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       block_bits;
    logic [7:0]       word_addr;
  } req_beat_t;

  // Tracks the sequencer state and holds the bus actions it must produce.
  class page_scoreboard;
    logic [7:0]       dev_sel;
    txn_phase_t       phase;
    logic             is_read;
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       addr_block;
    logic [7:0]       start_word;
    logic [7:0]       page_buf [PAGE_BYTES];
    rsp_t             action_q [$];
    int               failures;

    function new();
      dev_sel    = DEV_ADDR_RST;
      phase      = TP_IDLE;
      is_read    = 1'b0;
      byte_count = '0;
      addr_block = '0;
      start_word = '0;
      failures   = 0;
      foreach (page_buf[i]) page_buf[i] = '0;
    endfunction

    function void set_dev_sel(logic [7:0] value);
      dev_sel = value;
    endfunction

    function int pending();
      return action_q.size();
    endfunction

    function bit busy();
      return phase != TP_IDLE;
    endfunction

    // The last page byte is the one after which the count reaches a full page.
    function bit last_byte();
      return int'(byte_count) + 1 >= PAGE_BYTES;
    endfunction

    // Status code that the current phase waits for.
    function logic [7:0] expected_status();
      case (phase)
        TP_START:          return ST_START;
        TP_SLA_W:          return ST_SLA_W_ACK;
        TP_WORD, TP_WDATA: return ST_DATA_ACK;
        TP_RESTART:        return ST_RESTART;
        TP_SLA_R:          return ST_SLA_R_ACK;
        default:           return last_byte() ? ST_RX_NACK : ST_RX_ACK;
      endcase
    endfunction

    function act_t receive_action();
      return last_byte() ? ACT_RX_NACK : ACT_RX_ACK;
    endfunction

    // Advance the state on one accepted request beat and queue its response.
    function void note_request(req_beat_t b);
      rsp_t r;
      r = '0;
      case (b.func)
        FUNC_LOAD: begin
          if (int'(b.byte_index) < PAGE_BYTES) page_buf[b.byte_index] = b.data_byte;
        end
        FUNC_WRITE, FUNC_READ: begin
          if (phase == TP_IDLE) begin
            is_read    = (b.func == FUNC_READ);
            addr_block = b.block_bits;
            start_word = b.word_addr;
            byte_count = '0;
            phase      = TP_START;
            r.action   = ACT_START;
          end
        end
        default: begin
          if (phase != TP_IDLE) begin
            if (b.bus_status != expected_status()) begin
              // A failure in a data phase still releases the bus.
              r.action   = (phase == TP_WDATA || phase == TP_RDATA) ? ACT_STOP : ACT_NONE;
              r.done_res = 1'b1;
              r.failed   = 1'b1;
              phase      = TP_IDLE;
            end else begin
              case (phase)
                TP_START: begin
                  r.action  = ACT_TX;
                  r.tx_byte = dev_sel | addr_block;
                  phase     = TP_SLA_W;
                end
                TP_SLA_W: begin
                  r.action  = ACT_TX;
                  r.tx_byte = start_word;
                  phase     = TP_WORD;
                end
                TP_WORD: begin
                  if (is_read) begin
                    r.action = ACT_START;
                    phase    = TP_RESTART;
                  end else begin
                    byte_count = '0;
                    r.action   = ACT_TX;
                    r.tx_byte  = page_buf[0];
                    phase      = TP_WDATA;
                  end
                end
                TP_WDATA: begin
                  byte_count = byte_count + 1'b1;
                  if (int'(byte_count) >= PAGE_BYTES) begin
                    r.action   = ACT_STOP;
                    r.done_res = 1'b1;
                    phase      = TP_IDLE;
                  end else begin
                    r.action  = ACT_TX;
                    r.tx_byte = page_buf[byte_count[IDX_W-1:0]];
                  end
                end
                TP_RESTART: begin
                  r.action  = ACT_TX;
                  r.tx_byte = dev_sel | addr_block | RW_READ_BIT;
                  phase     = TP_SLA_R;
                end
                TP_SLA_R: begin
                  byte_count = '0;
                  r.action   = receive_action();
                  phase      = TP_RDATA;
                end
                default: begin
                  r.rx_valid = 1'b1;
                  r.rx_byte  = b.data_byte;
                  r.rx_index = byte_count[IDX_W-1:0];
                  byte_count = byte_count + 1'b1;
                  if (int'(byte_count) >= PAGE_BYTES) begin
                    r.action   = ACT_STOP;
                    r.done_res = 1'b1;
                    phase      = TP_IDLE;
                  end else begin
                    r.action = receive_action();
                  end
                end
              endcase
            end
          end
        end
      endcase
      action_q.push_back(r);
    endfunction

    function string describe(rsp_t r);
      return $sformatf("action=%0d tx=%h rx_valid=%b rx=%h idx=%0d done=%b failed=%b",
                       r.action, r.tx_byte, r.rx_valid, r.rx_byte, r.rx_index,
                       r.done_res, r.failed);
    endfunction

    function void note_failure(string what);
      failures++;
      if (failures <= REPORT_LIMIT) $display("[%0t] ERROR %s", $realtime, what);
    endfunction

    // Compare one accepted response beat with the oldest expectation.
    function void check_response(rsp_t got);
      rsp_t  want;
      string bad;
      if (action_q.size() == 0) begin
        note_failure({"response beat with nothing expected: got ", describe(got)});
        return;
      end
      want = action_q.pop_front();
      bad  = "";
      if (got.action !== want.action)     bad = {bad, " action"};
      if (got.tx_byte !== want.tx_byte)   bad = {bad, " tx_byte"};
      if (got.rx_valid !== want.rx_valid) bad = {bad, " rx_valid"};
      if (got.rx_byte !== want.rx_byte)   bad = {bad, " rx_byte"};
      if (got.rx_index !== want.rx_index) bad = {bad, " rx_index"};
      if (got.done_res !== want.done_res) bad = {bad, " done_res"};
      if (got.failed !== want.failed)     bad = {bad, " failed"};
      if (bad != "")
        note_failure({"mismatch in", bad, ": expected ", describe(want),
                      ", got ", describe(got)});
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady_tx;
  bit   steady_rx;
  int   beats_sent;

  page_scoreboard sb;

  eps_cfg_if cfg ();
  eps_req_if req ();
  eps_rsp_if rsp ();

  i2c_eeprom_page_sequencer dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_beat_t random_beat();
    req_beat_t b;
    b.func       = func_t'($urandom_range(0, 3));
    b.bus_status = 8'($urandom_range(0, 255));
    b.data_byte  = 8'($urandom_range(0, 255));
    b.byte_index = IDX_W'($urandom_range(0, PAGE_BYTES - 1));
    b.block_bits = 8'($urandom_range(0, 255));
    b.word_addr  = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic req_beat_t status_beat(logic [7:0] code);
    req_beat_t b;
    b            = random_beat();
    b.func       = FUNC_STATUS;
    b.bus_status = code;
    return b;
  endfunction

  function automatic req_beat_t start_beat(func_t kind, logic [7:0] blk, logic [7:0] word);
    req_beat_t b;
    b            = random_beat();
    b.func       = kind;
    b.block_bits = blk;
    b.word_addr  = word;
    return b;
  endfunction

  // Any status code other than the one the sequence waits for.
  function automatic logic [7:0] wrong_code(logic [7:0] right);
    logic [7:0] known [7];
    logic [7:0] c;
    known = '{ST_START, ST_SLA_W_ACK, ST_DATA_ACK, ST_RESTART,
              ST_SLA_R_ACK, ST_RX_ACK, ST_RX_NACK};
    do begin
      if ($urandom_range(0, 1)) c = known[$urandom_range(0, 6)];
      else c = 8'($urandom_range(0, 255));
    end while (c == right);
    return c;
  endfunction

  // Present one request beat after a random gap and hold it until taken.
  task automatic send_request(input req_beat_t b);
    int gap;
    gap = pick_gap(steady_tx);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.func       <= b.func;
    req.bus_status <= b.bus_status;
    req.data_byte  <= b.data_byte;
    req.byte_index <= b.byte_index;
    req.block_bits <= b.block_bits;
    req.word_addr  <= b.word_addr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(b);
    beats_sent++;
  endtask

  // Stop sending until every queued response has come back.
  task automatic wait_for_quiet();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_dev_sel(input logic [7:0] value);
    wait_for_quiet();
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.set_dev_sel(value);
    cfg.valid <= 1'b0;
  endtask

  // One page transaction driven to its end, with loads, stray starts and
  // sometimes a wrong status code mixed in.
  task automatic run_transaction();
    req_beat_t b;
    int        fail_at;
    int        n;
    int        k;
    steady_tx = ($urandom_range(0, 7) == 0);
    b = start_beat($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE,
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    send_request(b);
    fail_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 21) : -1;
    n = 0;
    while (sb.busy()) begin
      k = $urandom_range(0, 99);
      b = random_beat();
      if (k < 8) begin
        b.func = FUNC_LOAD;
      end else if (k < 10) begin
        b.func = $urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE;
      end else begin
        b = status_beat((n == fail_at) ? wrong_code(sb.expected_status())
                                       : sb.expected_status());
        n++;
      end
      if ($urandom_range(0, 199) == 0) wait_for_quiet();
      send_request(b);
    end
  endtask

  // Response side: random ready pattern, every accepted beat is checked.
  initial begin : response_sink
    rsp_t got;
    int   hold;
    bit   rx_on;
    rsp.ready <= 1'b0;
    steady_rx = 1'b0;
    hold  = 0;
    rx_on = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got.action   = act_t'(rsp.action);
        got.tx_byte  = rsp.tx_byte;
        got.rx_valid = rsp.rx_valid;
        got.rx_byte  = rsp.rx_byte;
        got.rx_index = rsp.rx_index;
        got.done_res = rsp.done_res;
        got.failed   = rsp.failed;
        sb.check_response(got);
      end
      if ($urandom_range(0, 63) == 0) steady_rx = !steady_rx;
      if (hold > 0) begin
        hold--;
      end else if (!rx_on) begin
        rx_on = 1'b1;
        rsp.ready <= 1'b1;
        hold = $urandom_range(0, 7);
      end else begin
        hold = pick_gap(steady_rx);
        if (hold > 0) begin
          rx_on = 1'b0;
          rsp.ready <= 1'b0;
          hold--;
        end else begin
          hold = $urandom_range(0, 7);
        end
      end
    end
  end

  // Ends a hung run: too many cycles in a row without any accepted beat.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (cfg.valid && cfg.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Main stimulus.
  initial begin : stimulus
    logic [7:0] addr_settings [5];
    req_beat_t  b;
    int         stop_at;
    sb = new();
    beats_sent = 0;
    steady_tx = 1'b0;
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.func       <= FUNC_LOAD;
    req.bus_status <= '0;
    req.data_byte  <= '0;
    req.byte_index <= '0;
    req.block_bits <= '0;
    req.word_addr  <= '0;
    cfg.valid      <= 1'b0;
    cfg.data       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole page first so no page write ever sends an unloaded byte.
    for (int i = 0; i < PAGE_BYTES; i++) begin
      b = random_beat();
      b.func       = FUNC_LOAD;
      b.byte_index = IDX_W'(i);
      if (i == 0) b.data_byte = 8'h00;
      else if (i == PAGE_BYTES - 1) b.data_byte = 8'hFF;
      send_request(b);
    end

    // Status while idle is ignored; a start while busy is ignored.
    send_request(status_beat(ST_START));
    send_request(start_beat(FUNC_READ, 8'hFF, 8'h00));
    send_request(start_beat(FUNC_WRITE, 8'h0E, 8'h55));
    send_request(status_beat(ST_START));
    // Wrong code before the data phase fails without a stop.
    send_request(status_beat(ST_DATA_ACK));
    send_request(start_beat(FUNC_WRITE, 8'h00, 8'hFF));
    send_request(status_beat(ST_START));
    send_request(status_beat(ST_SLA_W_ACK));
    send_request(status_beat(ST_DATA_ACK));
    // Wrong code in the data phase fails with a stop.
    send_request(status_beat(ST_RX_NACK));

    // Random phases, each under its own device address.
    addr_settings = '{8'hFE, 8'h00, 8'($urandom_range(0, 127) * 2),
                      8'($urandom_range(0, 254)), DEV_ADDR_RST};
    foreach (addr_settings[p]) begin
      write_dev_sel(addr_settings[p]);
      stop_at = beats_sent + PHASE_BEATS;
      while (beats_sent < stop_at) begin
        if ($urandom_range(0, 99) < 85) begin
          run_transaction();
        end else begin
          steady_tx = 1'b0;
          repeat ($urandom_range(1, 4)) send_request(random_beat());
        end
      end
      // A stray start may have left a transaction open.
      if (sb.busy()) run_transaction();
    end

    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/eps_pkg.sv
rtl/eps_ifs.sv
rtl/eps_page_buf.sv
rtl/eps_ctrl.sv
rtl/i2c_eeprom_page_sequencer.sv
tb/sv/tb_i2c_eeprom_page_sequencer.sv
